@@ rtl/multispin_metropolis_update_unit_macros.svh @@
// Assertion macros used by the checker of the multispin Metropolis update unit.
`ifndef MULTISPIN_METROPOLIS_UPDATE_UNIT_MACROS_SVH
`define MULTISPIN_METROPOLIS_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define MSMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msmu check failed: same-cycle implication");

// Next-cycle implication, checked only outside reset.
`define MSMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msmu check failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define MSMU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("msmu check failed: implication across reset");

`endif

@@ rtl/msmu_pkg.sv @@
// Types, constants and helper functions of the multispin Metropolis update unit.
package msmu_pkg;

    localparam int WORD_W      = 32;
    localparam int PAIR_W      = 2 * WORD_W;
    localparam int PAIR_COUNT  = 7;
    localparam int NEIGH_COUNT = 6;
    localparam int CNT_W       = $clog2(NEIGH_COUNT + 1);
    localparam int CFG_IDX_W   = $clog2(PAIR_COUNT + 1);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PAIR_W-1:0] t_pair;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_word ALL_ONES = '1;

    // Comparison outcome of the shared random value against every threshold pair.
    typedef struct packed {
        logic [PAIR_COUNT-1:0] uncond_hit;
        logic [PAIR_COUNT-1:0] fdep_hit;
    } t_hits;

    // Number of set bits among the six antiparallel flags of one replica.
    function automatic t_count count_ones6(logic [NEIGH_COUNT-1:0] flags);
        t_count sum;
        sum = '0;
        for (int j = 0; j < NEIGH_COUNT; j++) begin
            sum = sum + t_count'(flags[j]);
        end
        return sum;
    endfunction

endpackage

@@ rtl/msmu_ifs.sv @@
// Channel interfaces of the multispin Metropolis update unit: site beats, results, config writes.
interface msmu_site_if;
    logic           valid;
    logic           ready;
    msmu_pkg::t_word spin_word;
    msmu_pkg::t_word neighbour_xm;
    msmu_pkg::t_word neighbour_xp;
    msmu_pkg::t_word neighbour_ym;
    msmu_pkg::t_word neighbour_yp;
    msmu_pkg::t_word neighbour_zm;
    msmu_pkg::t_word neighbour_zp;
    msmu_pkg::t_word field_word;
    msmu_pkg::t_word random_value;

    modport source (
        output valid, spin_word, neighbour_xm, neighbour_xp, neighbour_ym,
               neighbour_yp, neighbour_zm, neighbour_zp, field_word, random_value,
        input  ready
    );
    modport sink (
        input  valid, spin_word, neighbour_xm, neighbour_xp, neighbour_ym,
               neighbour_yp, neighbour_zm, neighbour_zp, field_word, random_value,
        output ready
    );
endinterface

interface msmu_result_if;
    logic            valid;
    logic            ready;
    msmu_pkg::t_word new_spin_word;

    modport source (output valid, new_spin_word, input ready);
    modport sink (input valid, new_spin_word, output ready);
endinterface

interface msmu_cfg_if;
    logic               valid;
    logic               ready;
    msmu_pkg::t_cfg_idx reg_index;
    msmu_pkg::t_pair    wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/msmu_thr_cmp.sv @@
// Threshold pair registers and the fourteen compares against the shared random value.
module msmu_thr_cmp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    msmu_cfg_if.sink            i_cfg,
    input  msmu_pkg::t_word     i_random,
    output msmu_pkg::t_hits     o_hits
);

    msmu_pkg::t_pair r_pair [msmu_pkg::PAIR_COUNT];

    assign i_cfg.ready = 1'b1;

    // Writes to an index past the last pair are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < msmu_pkg::PAIR_COUNT; k++) begin
                r_pair[k] <= '0;
            end
        end else if (i_cfg.valid
                     && (i_cfg.reg_index < msmu_pkg::CFG_IDX_W'(msmu_pkg::PAIR_COUNT))) begin
            r_pair[i_cfg.reg_index] <= i_cfg.wr_data;
        end
    end

    always_comb begin
        for (int k = 0; k < msmu_pkg::PAIR_COUNT; k++) begin
            o_hits.uncond_hit[k] = (i_random <= r_pair[k][msmu_pkg::WORD_W-1:0]);
            o_hits.fdep_hit[k]   = (i_random <= r_pair[k][msmu_pkg::PAIR_W-1:msmu_pkg::WORD_W]);
        end
    end

endmodule

@@ rtl/multispin_metropolis_update_unit.sv @@
// Top level of the multispin Metropolis update unit: a three-stage site update pipeline.
//
//  Channel    Direction  Handshake      Beat contents
//  i_site     in         valid/ready    site word, six neighbour words, field word, random value
//  o_result   out        valid/ready    new site word
//  i_cfg      in         valid/ready    pair index (3 bits), 64-bit threshold pair
//
//  One site beat is taken per cycle while i_site.ready is high; a beat passes three register
//  stages (compare, count and mask build, output register) before its result shows.
//  The rate is set by the output register: a stall on o_result backs up stage by stage,
//  and i_site.ready drops only once all three stages hold a beat. i_cfg.ready is always high.
//  i_rst_n is synchronous; it empties the pipeline and clears all threshold pairs to zero.
//  Pairs are to be rewritten only while the pipeline is empty; the block leaves this to the user.
module multispin_metropolis_update_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    msmu_site_if.sink      i_site,
    msmu_result_if.source  o_result,
    msmu_cfg_if.sink       i_cfg
);

    // Stage enables. A stage may load when it is empty or when its content moves on.
    logic w_out_en;
    logic w_s2_en;
    logic w_s1_en;

    // Stage 1: antiparallel words, field-antiparallel word and threshold compare outcomes.
    logic              r_s1_valid;
    msmu_pkg::t_word   r_s1_site;
    msmu_pkg::t_word   r_s1_anti [msmu_pkg::NEIGH_COUNT];
    msmu_pkg::t_word   r_s1_fanti;
    msmu_pkg::t_hits   r_s1_hits;
    msmu_pkg::t_word   n_s1_anti [msmu_pkg::NEIGH_COUNT];
    msmu_pkg::t_hits   w_hits;

    // Stage 2: per-replica antiparallel counts and the seven candidate flip masks.
    logic              r_s2_valid;
    msmu_pkg::t_word   r_s2_site;
    msmu_pkg::t_count  r_s2_cnt   [msmu_pkg::WORD_W];
    msmu_pkg::t_word   r_s2_kmask [msmu_pkg::PAIR_COUNT];
    msmu_pkg::t_count  n_s2_cnt   [msmu_pkg::WORD_W];
    msmu_pkg::t_word   n_s2_kmask [msmu_pkg::PAIR_COUNT];

    // Stage 3: output register.
    logic              r_out_valid;
    msmu_pkg::t_word   r_out_word;
    msmu_pkg::t_word   n_out_word;

    assign w_out_en     = !r_out_valid || o_result.ready;
    assign w_s2_en      = !r_s2_valid  || w_out_en;
    assign w_s1_en      = !r_s1_valid  || w_s2_en;
    assign i_site.ready = w_s1_en;

    // The random value is compared against all fourteen thresholds in the first stage.
    msmu_thr_cmp u_thr_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_random (i_site.random_value),
        .o_hits   (w_hits)
    );

    // A neighbour bit that differs from the site bit marks an antiparallel bond.
    always_comb begin
        n_s1_anti[0] = i_site.spin_word ^ i_site.neighbour_xm;
        n_s1_anti[1] = i_site.spin_word ^ i_site.neighbour_xp;
        n_s1_anti[2] = i_site.spin_word ^ i_site.neighbour_ym;
        n_s1_anti[3] = i_site.spin_word ^ i_site.neighbour_yp;
        n_s1_anti[4] = i_site.spin_word ^ i_site.neighbour_zm;
        n_s1_anti[5] = i_site.spin_word ^ i_site.neighbour_zp;
    end

    // Bit-sliced counting: each replica bit gathers its six flags into a 3-bit count.
    // Each count gets its mask: all ones on an unconditional hit, else the
    // field-antiparallel replicas on a field-dependent hit, else nothing.
    always_comb begin
        for (int b = 0; b < msmu_pkg::WORD_W; b++) begin
            n_s2_cnt[b] = msmu_pkg::count_ones6({r_s1_anti[5][b], r_s1_anti[4][b],
                                                 r_s1_anti[3][b], r_s1_anti[2][b],
                                                 r_s1_anti[1][b], r_s1_anti[0][b]});
        end
        for (int k = 0; k < msmu_pkg::PAIR_COUNT; k++) begin
            if (r_s1_hits.uncond_hit[k]) begin
                n_s2_kmask[k] = msmu_pkg::ALL_ONES;
            end else if (r_s1_hits.fdep_hit[k]) begin
                n_s2_kmask[k] = r_s1_fanti;
            end else begin
                n_s2_kmask[k] = '0;
            end
        end
    end

    // The zero-count mask applies to every replica; the others only where the count matches.
    always_comb begin
        for (int b = 0; b < msmu_pkg::WORD_W; b++) begin
            n_out_word[b] = r_s2_site[b]
                          ^ (r_s2_kmask[0][b]
                             | ((r_s2_cnt[b] != '0) && r_s2_kmask[r_s2_cnt[b]][b]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_valid <= i_site.valid;
            end
            if (w_s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_en) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r_s1_site  <= i_site.spin_word;
            r_s1_anti  <= n_s1_anti;
            r_s1_fanti <= i_site.spin_word ^ i_site.field_word;
            r_s1_hits  <= w_hits;
        end
        if (w_s2_en) begin
            r_s2_site  <= r_s1_site;
            r_s2_cnt   <= n_s2_cnt;
            r_s2_kmask <= n_s2_kmask;
        end
        if (w_out_en) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.new_spin_word = r_out_word;

endmodule

@@ rtl/msmu_checker.sv @@
// Port-level checks of the multispin Metropolis update unit and their bind to the top level.
`include "multispin_metropolis_update_unit_macros.svh"

module msmu_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input msmu_pkg::t_word i_out_word
);

    // The input side only stalls when the whole pipeline is full behind a stalled result.
    `MSMU_ASSERT_NOW(a_backpressure_only_when_full, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

    // With the result side open while the beat moves through the later stages, an accepted beat shows up.
    `MSMU_ASSERT_NEXT(a_three_cycle_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready, i_out_valid)

    // A stalled result holds its value.
    `MSMU_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word))

    // Reset empties the pipeline.
    `MSMU_ASSERT_NEXT_ALWAYS(a_reset_empties, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind multispin_metropolis_update_unit msmu_checker u_msmu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_site.valid),
    .i_in_ready  (i_site.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_word  (o_result.new_spin_word)
);
